### rtl/ddc_pkg.sv
// Shared types, constants and tables of the date and day number converter.
package ddc_pkg;

  localparam int STAGES = 6;

  typedef enum logic {
    CMD_TO_COUNT = 1'b0,
    CMD_TO_DATE  = 1'b1
  } cmd_t;

  localparam logic [11:0] EPOCH_YEAR       = 12'd1900;
  localparam logic [17:0] QUAD_DAYS        = 18'd1461;
  localparam logic [17:0] QUAD_OFFSET      = 18'd233;
  localparam logic [10:0] FIVE_MONTHS      = 11'd153;
  localparam logic [15:0] MARCH_BIAS       = 16'd58;
  localparam logic [16:0] WEEK_DAYS        = 17'd7;
  localparam logic [15:0] LAST_JAN_COUNT   = 16'd30;
  localparam logic [15:0] QUAD_RECIP       = 16'd45933;
  localparam logic [9:0]  FIVE_MONTH_RECIP = 10'd856;
  localparam logic [13:0] WEEK_RECIP       = 14'd9362;
  localparam logic [7:0]  FIFTH_RECIP      = 8'd205;

  typedef struct packed {
    logic        command;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
    logic [15:0] day_number;
  } echo_t;

  typedef struct packed {
    logic [STAGES-1:0] load;
    logic [STAGES-1:0] valid;
    logic              in_ready;
  } pipe_ctl_t;

  // Days before the month in a March-based year: (153*m+2)/5
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] offs;
    case (month)
      4'd3:    offs = 9'd0;
      4'd4:    offs = 9'd31;
      4'd5:    offs = 9'd61;
      4'd6:    offs = 9'd92;
      4'd7:    offs = 9'd122;
      4'd8:    offs = 9'd153;
      4'd9:    offs = 9'd184;
      4'd10:   offs = 9'd214;
      4'd11:   offs = 9'd245;
      4'd12:   offs = 9'd275;
      4'd13:   offs = 9'd306;
      4'd14:   offs = 9'd337;
      4'd15:   offs = 9'd367;
      4'd0:    offs = 9'd275;
      4'd1:    offs = 9'd306;
      default: offs = 9'd337;
    endcase
    return offs;
  endfunction

endpackage

### rtl/ddc_in_if.sv
// Request channel of the converter: command, date and day number.
interface ddc_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [4:0]  day;
  logic [3:0]  month;
  logic [11:0] year;
  logic [15:0] day_number;

  modport source (output valid, command, day, month, year, day_number, input ready);
  modport sink (input valid, command, day, month, year, day_number, output ready);
endinterface

### rtl/ddc_out_if.sv
// Result channel of the converter: day count, date and weekday.
interface ddc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] day_count;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [11:0] out_year;
  logic [2:0]  weekday;

  modport source (output valid, day_count, out_day, out_month, out_year, weekday, input ready);
  modport sink (input valid, day_count, out_day, out_month, out_year, weekday, output ready);
endinterface

### rtl/ddc_pipe_ctrl.sv
// Valid bits and per-stage load enables of the converter pipeline.
module ddc_pipe_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output ddc_pkg::pipe_ctl_t  ctl
);

  logic [ddc_pkg::STAGES-1:0] valid;
  logic [ddc_pkg::STAGES:0]   ready;

  always_comb begin
    ready[ddc_pkg::STAGES] = out_ready;
    for (int k = ddc_pkg::STAGES - 1; k >= 0; k--) begin
      ready[k] = !valid[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < ddc_pkg::STAGES; k++) begin
        if (ready[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign ctl.load     = ready[ddc_pkg::STAGES-1:0];
  assign ctl.valid    = valid;
  assign ctl.in_ready = ready[0];

endmodule

### rtl/date_day_number_converter_unit.sv
// Top level of the date and day number converter pipeline.
// Converts between a calendar date and a 16-bit count of days since
// 1 January 1900, and gives the weekday (0 = Sunday) of every count.
// Channels: req (sink) carries command, day, month, year and day_number;
// rsp (source) carries day_count, out_day, out_month, out_year, weekday.
// Command 0 turns the date into a count and echoes the date; command 1
// turns day_number into a date and echoes the count.
// Throughput: one request per cycle while rsp.ready is high; six pipeline
// registers, most with a reciprocal multiply or a correcting subtract,
// set the depth, and rsp is driven from the stage 6 register.
// Stalls: req.ready falls only when all six stages hold requests and
// rsp.ready is low; a lower stage with a free slot keeps taking requests.
// Results hold on rsp until taken, in request order.
// Reset: rst clears every valid bit synchronously; the block then takes
// requests at once.
module date_day_number_converter_unit (
  input logic       clk,
  input logic       rst,
  ddc_in_if.sink    req,
  ddc_out_if.source rsp
);

  ddc_pkg::pipe_ctl_t ctl;

  ddc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl)
  );

  assign req.ready = ctl.in_ready;

  // stage 1
  ddc_pkg::echo_t echo_c;
  logic           borrow_c;
  logic [12:0]    y_c;
  logic [17:0]    t_c;
  logic [15:0]    spec_c;

  ddc_pkg::echo_t s1_e;
  logic [12:0]    s1_y;
  logic [17:0]    s1_t;
  logic [8:0]     s1_moff;
  logic [15:0]    s1_spec;
  logic           s1_zero;
  logic           s1_early0;
  logic           s1_early1;

  always_comb begin
    echo_c.command    = req.command;
    echo_c.day        = req.day;
    echo_c.month      = req.month;
    echo_c.year       = req.year;
    echo_c.day_number = req.day_number;
    borrow_c = req.month < 4'd3;
    y_c      = {1'b0, req.year} - {1'b0, ddc_pkg::EPOCH_YEAR} - {12'd0, borrow_c};
    t_c      = {req.day_number, 2'b00} - ddc_pkg::QUAD_OFFSET;
    spec_c   = (req.month == 4'd1) ? {11'd0, req.day} - 16'd1
                                    : {11'd0, req.day} + 16'd30;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      s1_e      <= echo_c;
      s1_y      <= y_c;
      s1_t      <= t_c;
      s1_moff   <= ddc_pkg::month_offset(req.month);
      s1_spec   <= spec_c;
      s1_zero   <= req.year == 12'd0;
      s1_early0 <= (req.year == ddc_pkg::EPOCH_YEAR) && borrow_c;
      s1_early1 <= req.day_number <= ddc_pkg::MARCH_BIAS;
    end
  end

  // stage 2
  logic [33:0]    pt_c;
  ddc_pkg::echo_t s2_e;
  logic [17:0]    s2_py;
  logic [7:0]     s2_q0;
  logic [17:0]    s2_t;
  logic [8:0]     s2_moff;
  logic [15:0]    s2_spec;
  logic           s2_zero;
  logic           s2_early0;
  logic           s2_early1;

  assign pt_c = {16'd0, s1_t} * {18'd0, ddc_pkg::QUAD_RECIP};

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      s2_e      <= s1_e;
      s2_py     <= {{5{s1_y[12]}}, s1_y} * ddc_pkg::QUAD_DAYS;
      s2_q0     <= pt_c[33:26];
      s2_t      <= s1_t;
      s2_moff   <= s1_moff;
      s2_spec   <= s1_spec;
      s2_zero   <= s1_zero;
      s2_early0 <= s1_early0;
      s2_early1 <= s1_early1;
    end
  end

  // stage 3
  logic [15:0]    count0_c;
  logic [15:0]    count_c;
  logic [17:0]    r0_c;
  logic           fix_c;
  ddc_pkg::echo_t s3_e;
  logic [15:0]    s3_count;
  logic [7:0]     s3_q;
  logic [10:0]    s3_r;
  logic           s3_early1;

  always_comb begin
    count0_c = s2_py[17:2] + {7'd0, s2_moff} + {11'd0, s2_e.day} + ddc_pkg::MARCH_BIAS;
    if (s2_e.command == ddc_pkg::CMD_TO_DATE) begin
      count_c = s2_e.day_number;
    end else if (s2_zero) begin
      count_c = 16'd0;
    end else if (s2_early0) begin
      count_c = s2_spec;
    end else begin
      count_c = count0_c;
    end
    r0_c  = s2_t - ({10'd0, s2_q0} * ddc_pkg::QUAD_DAYS);
    fix_c = r0_c >= ddc_pkg::QUAD_DAYS;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      s3_e      <= s2_e;
      s3_count  <= count_c;
      s3_q      <= fix_c ? s2_q0 + 8'd1 : s2_q0;
      s3_r      <= fix_c ? 11'(r0_c - ddc_pkg::QUAD_DAYS) : r0_c[10:0];
      s3_early1 <= s2_early1;
    end
  end

  // stage 4
  logic [16:0]    x_c;
  logic [30:0]    px_c;
  logic [10:0]    qq_c;
  logic [20:0]    pq_c;
  ddc_pkg::echo_t s4_e;
  logic [15:0]    s4_count;
  logic [7:0]     s4_q;
  logic           s4_early1;
  logic [16:0]    s4_x;
  logic [13:0]    s4_q7;
  logic [10:0]    s4_qq;
  logic [3:0]     s4_q2a;

  always_comb begin
    x_c  = {1'b0, s3_count} + 17'd1;
    px_c = {14'd0, x_c} * {17'd0, ddc_pkg::WEEK_RECIP};
    qq_c = ({2'd0, s3_r[10:2]} * 11'd5) + 11'd2;
    pq_c = {10'd0, qq_c} * {11'd0, ddc_pkg::FIVE_MONTH_RECIP};
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      s4_e      <= s3_e;
      s4_count  <= s3_count;
      s4_q      <= s3_q;
      s4_early1 <= s3_early1;
      s4_x      <= x_c;
      s4_q7     <= px_c[29:16];
      s4_qq     <= qq_c;
      s4_q2a    <= pq_c[20:17];
    end
  end

  // stage 5
  logic [16:0]    w0_c;
  logic [10:0]    rem0_c;
  logic           fix2_c;
  ddc_pkg::echo_t s5_e;
  logic [15:0]    s5_count;
  logic [7:0]     s5_q;
  logic           s5_early1;
  logic [2:0]     s5_wd;
  logic [3:0]     s5_q2;
  logic [7:0]     s5_rem;

  always_comb begin
    w0_c   = s4_x - ({3'd0, s4_q7} * ddc_pkg::WEEK_DAYS);
    rem0_c = s4_qq - ({7'd0, s4_q2a} * ddc_pkg::FIVE_MONTHS);
    fix2_c = rem0_c >= ddc_pkg::FIVE_MONTHS;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      s5_e      <= s4_e;
      s5_count  <= s4_count;
      s5_q      <= s4_q;
      s5_early1 <= s4_early1;
      s5_wd     <= (w0_c >= ddc_pkg::WEEK_DAYS) ? 3'(w0_c - ddc_pkg::WEEK_DAYS) : w0_c[2:0];
      s5_q2     <= fix2_c ? s4_q2a + 4'd1 : s4_q2a;
      s5_rem    <= fix2_c ? 8'(rem0_c - ddc_pkg::FIVE_MONTHS) : rem0_c[7:0];
    end
  end

  // stage 6: output register
  logic [14:0] pr_c;
  logic [4:0]  day_c;
  logic [3:0]  month_c;
  logic [11:0] year_c;
  logic [15:0] s6_count;
  logic [4:0]  s6_day;
  logic [3:0]  s6_month;
  logic [11:0] s6_year;
  logic [2:0]  s6_wd;

  always_comb begin
    pr_c = {7'd0, s5_rem} * {7'd0, ddc_pkg::FIFTH_RECIP};
    if (s5_e.command == ddc_pkg::CMD_TO_COUNT) begin
      day_c   = s5_e.day;
      month_c = s5_e.month;
      year_c  = s5_e.year;
    end else if (s5_early1) begin
      year_c = ddc_pkg::EPOCH_YEAR;
      if (s5_e.day_number <= ddc_pkg::LAST_JAN_COUNT) begin
        month_c = 4'd1;
        day_c   = s5_e.day_number[4:0] + 5'd1;
      end else begin
        month_c = 4'd2;
        day_c   = 5'(s5_e.day_number[5:0] - 6'd30);
      end
    end else begin
      day_c   = pr_c[14:10] + 5'd1;
      month_c = (s5_q2 < 4'd10) ? s5_q2 + 4'd3 : s5_q2 - 4'd9;
      year_c  = ddc_pkg::EPOCH_YEAR + {4'd0, s5_q} + {11'd0, s5_q2 >= 4'd10};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[5]) begin
      s6_count <= s5_count;
      s6_day   <= day_c;
      s6_month <= month_c;
      s6_year  <= year_c;
      s6_wd    <= s5_wd;
    end
  end

  assign rsp.valid     = ctl.valid[5];
  assign rsp.day_count = s6_count;
  assign rsp.out_day   = s6_day;
  assign rsp.out_month = s6_month;
  assign rsp.out_year  = s6_year;
  assign rsp.weekday   = s6_wd;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp.valid && !rsp.ready)
    else $error("request stalled while the pipeline has a free stage");

  a_year_remainder: assert property (@(posedge clk) disable iff (rst)
    ctl.valid[2] && s3_e.command == ddc_pkg::CMD_TO_DATE && !s3_early1
      |-> s3_r < ddc_pkg::QUAD_DAYS[10:0])
    else $error("year remainder out of range after correction");

  a_month_remainder: assert property (@(posedge clk) disable iff (rst)
    ctl.valid[4] && s5_e.command == ddc_pkg::CMD_TO_DATE && !s5_early1
      |-> s5_rem < ddc_pkg::FIVE_MONTHS[7:0] && s5_q2 < 4'd12)
    else $error("month quotient or remainder out of range");

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.weekday <= 3'd6)
    else $error("weekday out of range");

endmodule
